>>> sv/fwa_pkg.sv
// ----------------------------------------------------------------------------
// fwa_pkg: shared definitions for the fork waiter arbiter
// Field widths, request codes and the controller/datapath command and status
// structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fwa_pkg;

  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned HELD_W   = 5;

  localparam int unsigned DEF_MAX_REQ = 16;

  localparam logic [CFG_W-1:0]  NUM_RESET = 5'd5;
  localparam logic [HELD_W-1:0] HELD_MAX  = 5'd31;

  localparam logic [TYPE_W-1:0] REQ_LEFT    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RIGHT   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_NONE    = 2'd3;

  localparam logic KIND_LEFT  = 1'b0;
  localparam logic KIND_RIGHT = 1'b1;

  typedef struct packed {
    logic capture;
    logic src_queue;
    logic take;
    logic emit_direct;
    logic append;
    logic release_both;
    logic scan_start;
    logic scan_adv;
    logic keep;
    logic hold_load;
    logic push_mid;
    logic push_last;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              in_ring;
    logic              take_ok;
    logic              fill_full;
    logic              scan_end;
    logic              hold_vld;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/fwa_req_if.sv
// ----------------------------------------------------------------------------
// fwa_req_if: request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwa_req_if;
  import fwa_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [ID_W-1:0]   requester;

  modport source (output valid, output req_type, output requester, input ready);
  modport sink   (input valid, input req_type, input requester, output ready);
endinterface

`default_nettype wire

>>> sv/fwa_grant_if.sv
// ----------------------------------------------------------------------------
// fwa_grant_if: grant channel
// Valid/ready channel carrying one grant transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwa_grant_if;
  import fwa_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] grant_to;
  logic            last;

  modport source (output valid, output grant_to, output last, input ready);
  modport sink   (input valid, input grant_to, input last, output ready);
endinterface

`default_nettype wire

>>> sv/fwa_cfg_if.sv
// ----------------------------------------------------------------------------
// fwa_cfg_if: configuration write channel
// Valid/ready channel carrying the ring size register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwa_cfg_if;
  import fwa_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/fwa_ctrl.sv
// ----------------------------------------------------------------------------
// fwa_ctrl: arbiter sequencer
// Accepts a request, evaluates it, and walks the pending queue on a release.
// ----------------------------------------------------------------------------
`default_nettype none

module fwa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fwa_pkg::sts_t sts_i,
  output fwa_pkg::cmd_t      cmd_o
);
  import fwa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts_i.in_ring || sts_i.req_type == REQ_NONE) begin
          state_d = S_IDLE;
        end else if (sts_i.req_type == REQ_RELEASE) begin
          cmd_o.release_both = 1'b1;
          cmd_o.scan_start   = 1'b1;
          state_d            = S_SCAN;
        end else if (sts_i.take_ok) begin
          // hold the decision until the output register can take the grant
          if (sts_i.out_free) begin
            cmd_o.take        = 1'b1;
            cmd_o.emit_direct = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.append = !sts_i.fill_full;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.src_queue = 1'b1;
        if (sts_i.scan_end) begin
          if (!sts_i.hold_vld) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else if (sts_i.out_free) begin
            cmd_o.push_last = 1'b1;
            cmd_o.finish    = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (sts_i.take_ok) begin
          // the previous grant leaves as a non-final one
          if (!sts_i.hold_vld || sts_i.out_free) begin
            cmd_o.take      = 1'b1;
            cmd_o.scan_adv  = 1'b1;
            cmd_o.hold_load = 1'b1;
            cmd_o.push_mid  = sts_i.hold_vld;
          end
        end else begin
          cmd_o.keep     = 1'b1;
          cmd_o.scan_adv = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/fwa_datapath.sv
// ----------------------------------------------------------------------------
// fwa_datapath: resource state, pending queue and grant output
// Busy bits, held count, queue memory with compacting scan pointers, the
// pending-grant holding register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwa_datapath #(
  parameter int unsigned MaxRequesters = fwa_pkg::DEF_MAX_REQ
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fwa_pkg::cmd_t              cmd_i,
  output fwa_pkg::sts_t                   sts_o,
  input  wire logic [fwa_pkg::TYPE_W-1:0] req_type_i,
  input  wire logic [fwa_pkg::ID_W-1:0]   requester_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [fwa_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [fwa_pkg::ID_W-1:0]        grant_to_o,
  output logic                            last_o
);
  import fwa_pkg::*;

  localparam int unsigned QAW   = (MaxRequesters > 1) ? $clog2(MaxRequesters) : 1;
  localparam int unsigned QCW   = $clog2(MaxRequesters + 1);
  localparam int unsigned NMax  = (MaxRequesters > 31) ? 31 : MaxRequesters;
  localparam int unsigned BusyW = NMax;
  localparam int unsigned ResW  = (BusyW > 1) ? $clog2(BusyW) : 1;
  localparam int unsigned EntW  = ID_W + 1;

  localparam logic [CFG_W-1:0] RingMax = CFG_W'(NMax);
  localparam logic [CFG_W-1:0] RingMin = CFG_W'(2);
  localparam logic [QCW-1:0]   QDepth  = QCW'(MaxRequesters);

  logic [CFG_W-1:0]  num_q;
  logic [BusyW-1:0]  busy_q, busy_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [QCW-1:0]    fill_q, fill_d;
  logic [QCW-1:0]    rd_q, rd_d;
  logic [QCW-1:0]    wr_q, wr_d;
  logic [TYPE_W-1:0] req_type_q;
  logic [ID_W-1:0]   req_who_q;
  logic [ID_W-1:0]   hold_q;
  logic              hold_vld_q, hold_vld_d;
  logic              out_vld_q, out_vld_d;
  logic [ID_W-1:0]   out_to_q;
  logic              out_last_q;

  logic [EntW-1:0]   queue_mem [MaxRequesters];
  logic [EntW-1:0]   rdata_q;
  logic              mem_we;
  logic [QAW-1:0]    mem_waddr;
  logic [EntW-1:0]   mem_wdata;

  logic [CFG_W-1:0]  ring_n;
  logic              src_kind;
  logic [ID_W-1:0]   src_who;
  logic [CFG_W-1:0]  src_next;
  logic [CFG_W-1:0]  src_right;
  logic [CFG_W-1:0]  src_res;
  logic              src_in_ring;
  logic              src_hit;
  logic              left_block;
  logic              take_ok;
  logic [BusyW-1:0]  take_mask;
  logic [BusyW-1:0]  rel_mask;
  logic              out_free;

  // clamp the ring size into the supported range
  always_comb begin
    if (num_q < RingMin) begin
      ring_n = RingMin;
    end else if (num_q > RingMax) begin
      ring_n = RingMax;
    end else begin
      ring_n = num_q;
    end
  end

  // shared take check: captured request or queue head under scan
  assign src_kind    = cmd_i.src_queue ? rdata_q[ID_W] : req_type_q[0];
  assign src_who     = cmd_i.src_queue ? rdata_q[ID_W-1:0] : req_who_q;
  assign src_next    = {1'b0, src_who} + CFG_W'(1);
  assign src_right   = (src_next == ring_n) ? '0 : src_next;
  assign src_res     = (src_kind == KIND_RIGHT) ? src_right : {1'b0, src_who};
  assign src_in_ring = ({1'b0, src_who} < ring_n);
  assign src_hit     = busy_q[src_res[ResW-1:0]];
  assign left_block  = (src_kind == KIND_LEFT) && (held_q >= (ring_n - CFG_W'(1)));
  assign take_ok     = src_in_ring && !src_hit && !left_block;

  assign take_mask = BusyW'(1) << src_res;
  assign rel_mask  = (BusyW'(1) << req_who_q) | (BusyW'(1) << src_right);

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    busy_d = busy_q;
    held_d = held_q;
    if (cmd_i.release_both) begin
      busy_d = busy_q & ~rel_mask;
      held_d = (held_q >= HELD_W'(2)) ? held_q - HELD_W'(2) : '0;
    end else if (cmd_i.take) begin
      busy_d = busy_q | take_mask;
      held_d = (held_q == HELD_MAX) ? held_q : held_q + HELD_W'(1);
    end
  end

  // read pointer walks every entry once; write pointer compacts survivors
  always_comb begin
    rd_d   = rd_q;
    wr_d   = wr_q;
    fill_d = fill_q;
    if (cmd_i.scan_start) begin
      rd_d = '0;
      wr_d = '0;
    end else begin
      if (cmd_i.scan_adv) rd_d = rd_q + QCW'(1);
      if (cmd_i.keep)     wr_d = wr_q + QCW'(1);
    end
    if (cmd_i.append) begin
      fill_d = fill_q + QCW'(1);
    end else if (cmd_i.finish) begin
      fill_d = wr_q;
    end
  end

  always_comb begin
    mem_we    = cmd_i.append || cmd_i.keep;
    mem_waddr = cmd_i.keep ? wr_q[QAW-1:0] : fill_q[QAW-1:0];
    mem_wdata = cmd_i.keep ? rdata_q : {req_type_q[0], req_who_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) queue_mem[mem_waddr] <= mem_wdata;
    rdata_q <= queue_mem[rd_d[QAW-1:0]];
  end

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (cmd_i.hold_load) begin
      hold_vld_d = 1'b1;
    end else if (cmd_i.finish) begin
      hold_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (cmd_i.emit_direct || cmd_i.push_mid || cmd_i.push_last) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q      <= NUM_RESET;
      busy_q     <= '0;
      held_q     <= '0;
      fill_q     <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) num_q <= cfg_data_i;
      busy_q     <= busy_d;
      held_q     <= held_d;
      fill_q     <= fill_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      req_who_q  <= requester_i;
    end
    if (cmd_i.hold_load) hold_q <= src_who;
    if (cmd_i.emit_direct) begin
      out_to_q   <= req_who_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.push_mid) begin
      out_to_q   <= hold_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.push_last) begin
      out_to_q   <= hold_q;
      out_last_q <= 1'b1;
    end
  end

  always_comb begin
    sts_o.req_type  = req_type_q;
    sts_o.in_ring   = ({1'b0, req_who_q} < ring_n);
    sts_o.take_ok   = take_ok;
    sts_o.fill_full = (fill_q == QDepth);
    sts_o.scan_end  = (rd_q == fill_q);
    sts_o.hold_vld  = hold_vld_q;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_vld_q;
  assign grant_to_o  = out_to_q;
  assign last_o      = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QDepth)
    else $error("pending queue fill beyond depth");

  a_held_le_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) >= int'(held_q))
    else $error("held count exceeds busy resources");

  // pointers are only meaningful while a scan runs
  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.src_queue |-> ((wr_q <= rd_q) && (rd_q <= fill_q)))
    else $error("scan pointers out of order");

  a_last_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_last |-> (hold_vld_q && out_free))
    else $error("final grant pushed without a held grant or free output");

  a_push_drops_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !hold_vld_q)
    else $error("held grant survives end of scan");

endmodule

`default_nettype wire

>>> sv/fork_waiter_arbiter.sv
// ----------------------------------------------------------------------------
// fork_waiter_arbiter: waiter arbiter for a ring of requesters and resources
// Grants left/right resource requests, queues denied ones, and rescans the
// queue in order after every release.
// ----------------------------------------------------------------------------
// Usage:
//   req_i   - request transactions (req_type, requester). Ready is high only
//             while the sequencer is idle; one request is handled at a time.
//   grant_o - grant transactions (grant_to, last); last marks the final grant
//             caused by one request. A request may cause none.
//   cfg_i   - ring size writes, always ready; write only while idle.
// Timing: a left/right request is accepted, then evaluated, and its grant is
//   registered into the output register. A release is accepted, evaluated,
//   and then scans the pending requests in the queue memory at one entry per
//   cycle while no held grant waits for the output register, ending the scan.
//   Each scan grant is held back until the next one so the final one can carry last.
// Stall: a stalled grant stays in the output register; the sequencer pauses
//   only when it must load a new grant while the register is still full.
// Reset: all resources free, held count zero, queue empty, ring size 5.
// ----------------------------------------------------------------------------
`default_nettype none

module fork_waiter_arbiter #(
  parameter int unsigned MaxRequesters = fwa_pkg::DEF_MAX_REQ
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fwa_req_if.sink     req_i,
  fwa_grant_if.source grant_o,
  fwa_cfg_if.sink     cfg_i
);
  import fwa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  fwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fwa_datapath #(
    .MaxRequesters (MaxRequesters)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_i.req_type),
    .requester_i (req_i.requester),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (grant_o.valid),
    .out_ready_i (grant_o.ready),
    .grant_to_o  (grant_o.grant_to),
    .last_o      (grant_o.last)
  );

endmodule

`default_nettype wire

>>> dv/fwa_grant_checker.sv
// ----------------------------------------------------------------------------
// fwa_grant_checker: grant predictor and comparator for the fork waiter arbiter
// Watches the request, grant and ring size channels. Each accepted request is
// run through a local model of the ring (busy resources, held count, pending
// queue) and the grants it causes are queued. Each accepted grant is checked
// against the oldest queued grant.
// ----------------------------------------------------------------------------
`default_nettype none

module fwa_grant_checker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fwa_req_if          req,
  fwa_grant_if        grant,
  fwa_cfg_if          cfg,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import fwa_pkg::*;

  localparam int unsigned SLOTS = DEF_MAX_REQ;

  typedef struct packed {
    logic [ID_W-1:0] grant_to;
    logic            last;
  } grant_t;

  grant_t            grant_expect[$];
  int unsigned       mismatches = 0;

  logic [CFG_W-1:0]  ring_cfg;
  logic [SLOTS-1:0]  fork_busy;
  logic [HELD_W-1:0] forks_held;
  logic              wait_kind[SLOTS];
  logic [ID_W-1:0]   wait_owner[SLOTS];
  int unsigned       wait_fill;

  function automatic int unsigned ring_now();
    if (ring_cfg < 5'd2) return 2;
    if (ring_cfg > SLOTS) return SLOTS;
    return 32'(ring_cfg);
  endfunction

  // Take one resource if the rules allow it.
  function automatic bit try_fork(logic side, int unsigned who, int unsigned n);
    int unsigned res;
    if (who >= n) return 1'b0;
    res = (side == KIND_LEFT) ? who : ((who + 1 == n) ? 0 : who + 1);
    if (fork_busy[res]) return 1'b0;
    if (side == KIND_LEFT && forks_held >= n - 1) return 1'b0;
    fork_busy[res] = 1'b1;
    if (forks_held < HELD_MAX) forks_held++;
    return 1'b1;
  endfunction

  task automatic serve_request(logic [TYPE_W-1:0] code, logic [ID_W-1:0] who);
    int unsigned     n;
    int unsigned     slot;
    logic            side;
    logic [ID_W-1:0] won[$];
    grant_t          g;
    n = ring_now();
    if (who >= n || code == REQ_NONE) return;
    if (code == REQ_LEFT || code == REQ_RIGHT) begin
      side = (code == REQ_LEFT) ? KIND_LEFT : KIND_RIGHT;
      if (try_fork(side, 32'(who), n)) begin
        won.push_back(who);
      end else if (wait_fill < SLOTS) begin
        wait_kind[wait_fill]  = side;
        wait_owner[wait_fill] = who;
        wait_fill++;
      end
    end else begin
      fork_busy[who] = 1'b0;
      fork_busy[(who + 1 == n) ? 0 : who + 1] = 1'b0;
      forks_held = (forks_held >= 2) ? forks_held - 5'd2 : 5'd0;
      // Rescan oldest first; close up the queue behind each grant.
      slot = 0;
      while (slot < wait_fill) begin
        if (try_fork(wait_kind[slot], 32'(wait_owner[slot]), n)) begin
          won.push_back(wait_owner[slot]);
          for (int unsigned j = slot + 1; j < wait_fill; j++) begin
            wait_kind[j-1]  = wait_kind[j];
            wait_owner[j-1] = wait_owner[j];
          end
          wait_fill--;
        end else begin
          slot++;
        end
      end
    end
    foreach (won[i]) begin
      g.grant_to = won[i];
      g.last     = (i == won.size() - 1);
      grant_expect.push_back(g);
    end
  endtask

  task automatic check_grant(logic [ID_W-1:0] to, logic lst);
    grant_t want;
    if (grant_expect.size() == 0) begin
      $error("grant_to: no grant expected, actual %0d", to);
      mismatches++;
      return;
    end
    want = grant_expect.pop_front();
    if (want.grant_to !== to) begin
      $error("grant_to mismatch: expected %0d, actual %0d", want.grant_to, to);
      mismatches++;
    end
    if (want.last !== lst) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, lst);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cfg   = NUM_RESET;
      fork_busy  = '0;
      forks_held = '0;
      wait_fill  = 0;
      grant_expect.delete();
    end else begin
      if (cfg.valid && cfg.ready) ring_cfg = cfg.data;
      if (req.valid && req.ready) serve_request(req.req_type, req.requester);
      if (grant.valid && grant.ready) check_grant(grant.grant_to, grant.last);
    end
    errors_o  <= mismatches;
    pending_o <= grant_expect.size();
  end

endmodule

`default_nettype wire

>>> dv/tb_fork_waiter_arbiter.sv
// ----------------------------------------------------------------------------
// tb_fork_waiter_arbiter: stimulus and verdict for the fork waiter arbiter
// Drives a directed opening (grants, count limit, multi-grant release, queue
// overflow, ignored items) and then random dining sequences mixed with noise
// over several ring sizes, with random stalls on both channels and one long
// grant hold-off. Checking is done by fwa_grant_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fork_waiter_arbiter;
  import fwa_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned errors;
  int unsigned pending;

  bit               idle_on;
  bit               pressure_armed;
  logic [CFG_W-1:0] ring_cfg;
  int unsigned      meal_step[DEF_MAX_REQ];
  logic             first_side[DEF_MAX_REQ];

  fwa_req_if   req_ch ();
  fwa_grant_if grant_ch ();
  fwa_cfg_if   cfg_ch ();

  fork_waiter_arbiter i_dut (
    .clk_i,
    .rst_ni,
    .req_i   (req_ch),
    .grant_o (grant_ch),
    .cfg_i   (cfg_ch)
  );

  fwa_grant_checker i_checker (
    .clk_i,
    .rst_ni,
    .req       (req_ch),
    .grant     (grant_ch),
    .cfg       (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned ring_now();
    if (ring_cfg < 5'd2) return 2;
    if (ring_cfg > DEF_MAX_REQ) return DEF_MAX_REQ;
    return 32'(ring_cfg);
  endfunction

  task automatic offer(logic [TYPE_W-1:0] code, logic [ID_W-1:0] who);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= code;
    req_ch.requester <= who;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Wait for every grant, then let a trailing rescan finish.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ring(logic [CFG_W-1:0] size);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= size;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ring_cfg = size;
  endtask

  task automatic run_directed();
    offer(REQ_LEFT, 4'd0);
    offer(REQ_LEFT, 4'd1);
    offer(REQ_LEFT, 4'd2);
    offer(REQ_LEFT, 4'd3);
    // Held count at the limit: a free left resource is still refused.
    offer(REQ_LEFT, 4'd4);
    offer(REQ_RIGHT, 4'd4);
    offer(REQ_NONE, 4'd2);
    offer(REQ_LEFT, 4'd15);
    // Release grants both queued requests in one transaction.
    offer(REQ_RELEASE, 4'd0);
    offer(REQ_RELEASE, 4'd4);
    // Overflow the pending queue by one.
    repeat (DEF_MAX_REQ + 1) offer(REQ_RIGHT, 4'd1);
    offer(REQ_RELEASE, 4'd1);
    offer(REQ_RELEASE, 4'd3);
  endtask

  task automatic random_items(int unsigned count);
    int unsigned      sent;
    int unsigned      n;
    int unsigned      who;
    logic [TYPE_W-1:0] code;
    sent = 0;
    while (sent < count) begin
      n = ring_now();
      if ($urandom_range(0, 9) < 8) begin
        // Dining sequence: one fork, the other fork, release.
        who = $urandom_range(0, n - 1);
        case (meal_step[who])
          0: begin
            first_side[who] = 1'($urandom_range(0, 1));
            code = first_side[who] ? REQ_RIGHT : REQ_LEFT;
          end
          1: begin
            code = first_side[who] ? REQ_LEFT : REQ_RIGHT;
          end
          default: begin
            code = REQ_RELEASE;
          end
        endcase
        meal_step[who] = (meal_step[who] + 1) % 3;
      end else begin
        code = TYPE_W'($urandom_range(0, 3));
        who  = $urandom_range(0, 15);
      end
      offer(code, ID_W'(who));
      if (who < n && code != REQ_NONE) sent++;
    end
  endtask

  initial begin : grant_sink
    int unsigned gap;
    bit          pressure_done;
    pressure_done  = 1'b0;
    grant_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_armed && !pressure_done) begin
        // Hold off long enough for the block to back up into the request side.
        pressure_done = 1'b1;
        grant_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        grant_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(1, 14);
        grant_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        grant_ch.ready <= 1'b1;
      end else begin
        grant_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (grant_ch.valid && grant_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("fork_waiter_arbiter verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_NONE;
    req_ch.requester = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    ring_cfg         = NUM_RESET;
    idle_on          = 1'b1;
    pressure_armed   = 1'b0;
    foreach (meal_step[i]) begin
      meal_step[i]  = 0;
      first_side[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    set_ring(5'd2);
    random_items(60);
    set_ring(5'd16);
    pressure_armed = 1'b1;
    random_items(90);
    set_ring(5'd0);
    random_items(50);
    set_ring(5'd31);
    random_items(60);
    set_ring(5'd3);
    random_items(60);
    repeat (2) begin
      set_ring(CFG_W'($urandom_range(2, 16)));
      idle_on = ($urandom_range(0, 3) != 0);
      random_items(60);
    end
    // Closing stretch runs at full rate on both sides.
    idle_on = 1'b0;
    set_ring(CFG_W'($urandom_range(2, 16)));
    random_items(50);
    drain();

    if (errors == 0) begin
      $display("fork_waiter_arbiter verification clean");
    end else begin
      $display("fork_waiter_arbiter verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
